// ----- hw/rtl/abt_pkg.sv -----
package abt_pkg;

	localparam int BLOCK_MAX = 16;
	localparam int DATA_W    = 8;
	localparam int BLEN_W    = 5;
	localparam int LEN_W     = $clog2(BLOCK_MAX + 1);
	localparam int POS_W     = $clog2(BLOCK_MAX);
	localparam int SUM_W     = LEN_W + 1;
	localparam int APB_DW    = 32;
	localparam int ADDR_W    = 4;
	localparam int CALC_N    = 2 * DATA_W;
	localparam int CNT_W     = $clog2(CALC_N);

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [POS_W-1:0] pos_t;

	localparam logic [1:0] REG_BLOCK_LEN = 2'd0;
	localparam logic [1:0] REG_MULT      = 2'd1;
	localparam logic [1:0] REG_OFFSET    = 2'd2;

	localparam logic [BLEN_W-1:0] BLOCK_LEN_RST = BLEN_W'(5);
	localparam logic [DATA_W-1:0] MULT_RST      = DATA_W'(3);
	localparam logic [DATA_W-1:0] OFFSET_RST    = DATA_W'(2);

	function automatic len_t eff_len(input logic [BLEN_W-1:0] bl);
		len_t r;
		if (bl == '0) begin
			r = len_t'(1);
		end else if (32'(bl) > 32'(BLOCK_MAX)) begin
			r = len_t'(BLOCK_MAX);
		end else begin
			r = len_t'(bl);
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/affine_block_transposition_core.sv -----
// Affine block transposition. Byte j of a block goes to position (mult*j + offset) mod
// the effective length (block_len, with 0 read as 1 and more than 16 as 16); a full block,
// or a short one closed by end_of_stream (zero padded), is then sent out in position order
// with block_end on its last byte, unreached positions as zero. A short block first places
// its padding bytes as zeros; the bytes are sent as out_ready allows, and input is held
// off until the last byte is in the output register. After reset and after every write to
// block_len, mult or offset the block works out offset and mult modulo the length, one bit
// per cycle on the shared add/compare unit that also advances the target position;
// in_ready is low during that time.
module affine_block_transposition_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [abt_pkg::DATA_W-1:0]    in_byte,
	input  logic                          end_of_stream,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [abt_pkg::DATA_W-1:0]    out_byte,
	output logic                          block_end,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abt_pkg::ADDR_W-1:0]    paddr,
	input  logic [abt_pkg::APB_DW-1:0]    pwdata,
	output logic [abt_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam logic [1:0] ST_CALC = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_PAD  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                       state_q;
	logic [abt_pkg::BLEN_W-1:0]       block_len_q;
	logic [abt_pkg::DATA_W-1:0]       mult_q;
	logic [abt_pkg::DATA_W-1:0]       offset_q;
	logic [abt_pkg::CNT_W-1:0]        cnt_q;
	abt_pkg::pos_t                    rem_q;
	abt_pkg::pos_t                    off_mod_q;
	abt_pkg::pos_t                    step_q;
	abt_pkg::pos_t                    pos_q;
	abt_pkg::pos_t                    emit_q;
	abt_pkg::len_t                    load_idx_q;
	logic [abt_pkg::BLOCK_MAX-1:0]    mask_q;
	logic [abt_pkg::DATA_W-1:0]       store_q [abt_pkg::BLOCK_MAX];
	logic                             out_valid_q;
	logic [abt_pkg::DATA_W-1:0]       out_byte_q;
	logic                             block_end_q;

	abt_pkg::len_t                    len_eff;
	logic                             cfg_wr;
	logic                             cfg_hit;
	logic [abt_pkg::DATA_W-1:0]       div_src;
	logic                             div_bit;
	abt_pkg::pos_t                    ux;
	abt_pkg::pos_t                    uy;
	logic                             cin;
	logic [abt_pkg::SUM_W-1:0]        sum;
	logic [abt_pkg::SUM_W-1:0]        res;
	abt_pkg::pos_t                    res_pos;
	logic                             accept;
	logic                             place;
	abt_pkg::len_t                    idx_next;
	logic                             emit_go;
	logic                             emit_last;

	assign len_eff = abt_pkg::eff_len(block_len_q);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_hit = cfg_wr && (paddr[3:2] == abt_pkg::REG_BLOCK_LEN
		|| paddr[3:2] == abt_pkg::REG_MULT || paddr[3:2] == abt_pkg::REG_OFFSET);

	always_comb begin
		case (paddr[3:2])
			abt_pkg::REG_BLOCK_LEN: prdata = abt_pkg::APB_DW'(block_len_q);
			abt_pkg::REG_MULT:      prdata = abt_pkg::APB_DW'(mult_q);
			abt_pkg::REG_OFFSET:    prdata = abt_pkg::APB_DW'(offset_q);
			default:                prdata = '0;
		endcase
	end

	// shared add / conditional-subtract unit: division steps and position advance
	assign div_src = cnt_q[abt_pkg::CNT_W-1] ? mult_q : offset_q;
	assign div_bit = div_src[3'(abt_pkg::DATA_W - 1) - cnt_q[2:0]];

	always_comb begin
		if (state_q == ST_CALC) begin
			ux  = rem_q;
			uy  = rem_q;
			cin = div_bit;
		end else begin
			ux  = pos_q;
			uy  = step_q;
			cin = 1'b0;
		end
		sum = abt_pkg::SUM_W'(ux) + abt_pkg::SUM_W'(uy) + abt_pkg::SUM_W'(cin);
		if (sum >= abt_pkg::SUM_W'(len_eff)) begin
			res = sum - abt_pkg::SUM_W'(len_eff);
		end else begin
			res = sum;
		end
		res_pos = res[abt_pkg::POS_W-1:0];
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign place     = accept || (state_q == ST_PAD);
	assign idx_next  = load_idx_q + abt_pkg::len_t'(1);
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign emit_last = (abt_pkg::len_t'(emit_q) + abt_pkg::len_t'(1)) == len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CALC;
			block_len_q <= abt_pkg::BLOCK_LEN_RST;
			mult_q      <= abt_pkg::MULT_RST;
			offset_q    <= abt_pkg::OFFSET_RST;
			cnt_q       <= '0;
			rem_q       <= '0;
			off_mod_q   <= '0;
			step_q      <= '0;
			pos_q       <= '0;
			emit_q      <= '0;
			load_idx_q  <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && !(emit_go && !cfg_hit)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				case (paddr[3:2])
					abt_pkg::REG_BLOCK_LEN: block_len_q <= pwdata[abt_pkg::BLEN_W-1:0];
					abt_pkg::REG_MULT:      mult_q      <= pwdata[abt_pkg::DATA_W-1:0];
					default:                offset_q    <= pwdata[abt_pkg::DATA_W-1:0];
				endcase
				state_q    <= ST_CALC;
				cnt_q      <= '0;
				rem_q      <= '0;
				load_idx_q <= '0;
				mask_q     <= '0;
			end else begin
				case (state_q)
					ST_CALC: begin
						cnt_q <= cnt_q + abt_pkg::CNT_W'(1);
						if (cnt_q == abt_pkg::CNT_W'(abt_pkg::DATA_W - 1)) begin
							off_mod_q <= res_pos;
							rem_q     <= '0;
						end else if (cnt_q == abt_pkg::CNT_W'(abt_pkg::CALC_N - 1)) begin
							step_q     <= res_pos;
							pos_q      <= off_mod_q;
							load_idx_q <= '0;
							mask_q     <= '0;
							state_q    <= ST_IDLE;
						end else begin
							rem_q <= res_pos;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							if (idx_next >= len_eff) begin
								state_q <= ST_EMIT;
								emit_q  <= '0;
							end else if (end_of_stream) begin
								state_q <= ST_PAD;
							end
						end
					end
					ST_PAD: begin
						if (idx_next >= len_eff) begin
							state_q <= ST_EMIT;
							emit_q  <= '0;
						end
					end
					ST_EMIT: begin
						if (emit_go) begin
							out_valid_q <= 1'b1;
							emit_q      <= emit_q + abt_pkg::pos_t'(1);
							if (emit_last) begin
								state_q    <= ST_IDLE;
								pos_q      <= off_mod_q;
								load_idx_q <= '0;
								mask_q     <= '0;
							end
						end
					end
					default: state_q <= ST_CALC;
				endcase
				if (place) begin
					mask_q[pos_q] <= 1'b1;
					load_idx_q    <= idx_next;
					pos_q         <= res_pos;
				end
			end
		end
	end

	// block store and output register payload
	always_ff @(posedge clk) begin
		if (place && !cfg_hit) begin
			store_q[pos_q] <= accept ? in_byte : '0;
		end
		if (emit_go && !cfg_hit) begin
			out_byte_q  <= mask_q[emit_q] ? store_q[emit_q] : '0;
			block_end_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign block_end = block_end_q;

endmodule

// ----- hw/rtl/abt_checker.sv -----
module abt_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [abt_pkg::DATA_W-1:0]    out_byte,
	input  logic                          block_end,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abt_pkg::ADDR_W-1:0]    paddr
);

	// stalled result request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(block_end))
		else $error("output request changed while stalled");

	// mid-block: no new input until the whole block is out
	a_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !block_end |-> !in_ready)
		else $error("input taken while a block is being emitted");

	// register write restarts the modulo setup
	a_cfg_setup: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[3:2] == abt_pkg::REG_BLOCK_LEN
		|| paddr[3:2] == abt_pkg::REG_MULT || paddr[3:2] == abt_pkg::REG_OFFSET)
		|=> !in_ready)
		else $error("input ready straight after register write");

endmodule

bind affine_block_transposition_core abt_checker u_abt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.block_end (block_end),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr)
);

// ----- tb/testbench.sv -----
module testbench;

	localparam logic [1:0] REG_SPARE   = 2'd3;
	localparam int         QUIET_LIMIT = 1000;

	typedef struct packed {
		logic [abt_pkg::DATA_W-1:0] data;
		logic                       tail;
	} perm_byte_t;

	class affine_block_tracker;
		logic [abt_pkg::BLEN_W-1:0]    block_len;
		logic [abt_pkg::DATA_W-1:0]    mult;
		logic [abt_pkg::DATA_W-1:0]    offset;
		logic [abt_pkg::DATA_W-1:0]    slot [abt_pkg::BLOCK_MAX];
		logic [abt_pkg::BLOCK_MAX-1:0] filled;
		int                            loaded;
		int                            target;
		perm_byte_t                    permuted [$];
		int                            errors;

		function new();
			block_len = abt_pkg::BLOCK_LEN_RST;
			mult      = abt_pkg::MULT_RST;
			offset    = abt_pkg::OFFSET_RST;
			foreach (slot[i]) slot[i] = '0;
			errors = 0;
			restart();
		endfunction

		function int block_size();
			int n;
			n = int'(block_len);
			if (n == 0) begin
				return 1;
			end
			if (n > abt_pkg::BLOCK_MAX) begin
				return abt_pkg::BLOCK_MAX;
			end
			return n;
		endfunction

		function void restart();
			filled = '0;
			loaded = 0;
			target = int'(offset) % block_size();
		endfunction

		function bit idle();
			return permuted.size() == 0;
		endfunction

		function void write_register(logic [1:0] idx, logic [abt_pkg::APB_DW-1:0] value);
			case (idx)
				abt_pkg::REG_BLOCK_LEN: block_len = value[abt_pkg::BLEN_W-1:0];
				abt_pkg::REG_MULT:      mult = value[abt_pkg::DATA_W-1:0];
				abt_pkg::REG_OFFSET:    offset = value[abt_pkg::DATA_W-1:0];
				default:                return;
			endcase
			restart();
		endfunction

		function void drop_byte(logic [abt_pkg::DATA_W-1:0] b);
			int n;
			int pos;
			n   = block_size();
			pos = target % n;
			slot[abt_pkg::pos_t'(pos)]   = b;
			filled[abt_pkg::pos_t'(pos)] = 1'b1;
			loaded++;
			pos += int'(mult) % n;
			if (pos >= n) begin
				pos -= n;
			end
			target = pos;
		endfunction

		function void take_byte(logic [abt_pkg::DATA_W-1:0] b, logic eos);
			int         n;
			perm_byte_t e;
			n = block_size();
			drop_byte(b);
			if (loaded < n && !eos) begin
				return;
			end
			// short block: zero padding goes through the same map
			while (loaded < n) drop_byte('0);
			for (int p = 0; p < n; p++) begin
				e.data = filled[abt_pkg::pos_t'(p)] ? slot[abt_pkg::pos_t'(p)] : '0;
				e.tail = (p == n - 1);
				permuted.push_back(e);
			end
			restart();
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task match_output(logic [abt_pkg::DATA_W-1:0] data, logic tail);
			perm_byte_t e;
			if (permuted.size() == 0) begin
				report($sformatf("unexpected byte %02h block_end %b", data, tail));
				return;
			end
			e = permuted.pop_front();
			if (e.data !== data) begin
				report($sformatf("out_byte %02h, expected %02h", data, e.data));
			end
			if (e.tail !== tail) begin
				report($sformatf("block_end %b, expected %b", tail, e.tail));
			end
		endtask
	endclass

	logic                       clk;
	logic                       arst_n        = 1'b0;
	logic                       in_valid      = 1'b0;
	logic                       in_ready;
	logic [abt_pkg::DATA_W-1:0] in_byte       = '0;
	logic                       end_of_stream = 1'b0;
	logic                       out_valid;
	logic                       out_ready     = 1'b0;
	logic [abt_pkg::DATA_W-1:0] out_byte;
	logic                       block_end;
	logic                       psel          = 1'b0;
	logic                       penable       = 1'b0;
	logic                       pwrite        = 1'b0;
	logic [abt_pkg::ADDR_W-1:0] paddr         = '0;
	logic [abt_pkg::APB_DW-1:0] pwdata        = '0;
	logic [abt_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	affine_block_tracker tracker;
	bit                  steady = 1'b0;
	int                  quiet  = 0;

	affine_block_transposition_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.block_end     (block_end),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_byte(input logic [abt_pkg::DATA_W-1:0] b, input logic eos);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(b, eos);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (!tracker.idle()) @(posedge clk);
	endtask

	// idle, plus time for a partial load still in flight
	task automatic settle();
		quiesce();
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [abt_pkg::APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= abt_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int bl, input int m, input int o);
		settle();
		apb_write(abt_pkg::REG_BLOCK_LEN, ($urandom & 32'hFFFF_FFE0) | 32'(bl));
		apb_write(abt_pkg::REG_MULT, ($urandom & 32'hFFFF_FF00) | 32'(m));
		apb_write(abt_pkg::REG_OFFSET, ($urandom & 32'hFFFF_FF00) | 32'(o));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.match_output(out_byte, block_end);
		end
	end

	initial begin
		int run;
		int stall;
		forever begin
			@(posedge clk);
			run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			out_ready <= 1'b0;
			repeat (stall - 1) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int r;
		int bl;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full block, short block, end of stream on a full block
		steady = 1'b1;
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h01, 1'b0);
		steady = 1'b0;
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		for (int i = 0; i < 5; i++) send_byte(abt_pkg::DATA_W'(8'h10 + i), i == 4);

		// zero length taken as one
		configure(0, 0, 255);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h01, 1'b1);

		// oversize length, even multiplier leaves holes
		configure(17, 2, 255);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h99, 1'b1);

		// write to an unlisted register must not disturb the partial block
		configure(16, 255, 0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hED, 1'b0);
		settle();
		apb_write(REG_SPARE, $urandom);
		send_byte(8'h66, 1'b1);

		// every byte collides on one position
		configure(31, 0, 3);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				bl = $urandom_range(1, 8);
			end else if (r < 7) begin
				bl = $urandom_range(9, 16);
			end else if (r < 8) begin
				bl = 0;
			end else begin
				bl = $urandom_range(17, 31);
			end
			configure(bl, $urandom_range(0, 255), $urandom_range(0, 255));
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 25; k++) begin
				if (k == 12 && ph % 3 == 1) begin
					quiesce();
				end
				send_byte(abt_pkg::DATA_W'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
			end
		end

		quiesce();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.idle()) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
